// ===== sv/xmodem_crc_receiver_assert.svh =====
// assertion macros shared by the receiver rtl
`ifndef XMODEM_CRC_RECEIVER_ASSERT_SVH
`define XMODEM_CRC_RECEIVER_ASSERT_SVH

// same-cycle implication, sampled on clk, off during rst
`define XCR_ASSERT_IMPL(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, sampled on clk, off during rst
`define XCR_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== sv/xcr_pkg.sv =====
// constants, types and the crc step for the xmodem crc receiver
`timescale 1ns / 1ps

package xcr_pkg;

  // frame and flash geometry
  localparam int PAYLOAD_BYTES     = 128;
  localparam int ERASE_BLOCK_BYTES = 65536;
  localparam int FLASH_BYTES       = 16777216;

  localparam int ADDR_W       = 24;
  localparam int COUNT_W      = 25;
  localparam int SUM_W        = 26;
  localparam int BLOCK_SHIFT  = $clog2(ERASE_BLOCK_BYTES);
  localparam int BLOCK_IDX_W  = ADDR_W - BLOCK_SHIFT;

  localparam logic [7:0] PAYLOAD_END  = 8'(3 + PAYLOAD_BYTES);
  localparam logic [7:0] CRC_HIGH_POS = 8'(3 + PAYLOAD_BYTES);
  localparam logic [7:0] FRAME_LAST   = 8'(4 + PAYLOAD_BYTES);
  localparam logic [7:0] POS_SEQ      = 8'd1;
  localparam logic [7:0] POS_COMP     = 8'd2;
  localparam logic [7:0] POS_FIRST_PL = 8'd3;

  // protocol bytes
  localparam logic [7:0] SOH_BYTE = 8'h01;
  localparam logic [7:0] EOT_BYTE = 8'h04;

  localparam logic [15:0] CRC_POLY = 16'h1021;

  // event codes on the result channel
  localparam logic [2:0] EV_NONE    = 3'd0;
  localparam logic [2:0] EV_PAYLOAD = 3'd1;
  localparam logic [2:0] EV_ACK     = 3'd2;
  localparam logic [2:0] EV_NAK     = 3'd3;
  localparam logic [2:0] EV_CANCEL  = 3'd4;
  localparam logic [2:0] EV_END     = 3'd5;

  // input action codes
  localparam logic ACT_BYTE  = 1'b0;
  localparam logic ACT_START = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ACTIVE,
    ST_ENDED,
    ST_CANCELLED
  } session_status_t;

  // one byte of crc-16 ccitt, msb first, eight shift steps
  function automatic logic [15:0] crc16_byte(input logic [15:0] crc_in,
                                              input logic [7:0]  data);
    logic [15:0] crc;
    crc = crc_in ^ {data, 8'h00};
    for (int i = 0; i < 8; i++) begin
      if (crc[15]) begin
        crc = {crc[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        crc = {crc[14:0], 1'b0};
      end
    end
    return crc;
  endfunction

endpackage

// ===== sv/xmodem_crc_receiver.sv =====
// xmodem crc receiver: frame parser, crc check and flash target tracking
//
// Input channel (in_valid / in_stall) carries one transaction per serial
// byte: action 0 is a received byte, action 1 opens a new session. Each
// transaction yields exactly one result on the output channel
// (out_valid / out_stall): an event code with the payload byte and offset,
// the flash address of the current packet, erase request and block index
// on ack, the accepted byte total and the lowest and highest erase block.
// The configuration register start_address must be written with cfg_write
// and cfg_data only while no transaction is in flight; the block itself
// does not enforce this. A byte lands in the input register, then one pass
// of parser, crc-16 byte update and 26-bit address add loads the result
// register. Throughput is one transaction per cycle while the output does
// not stall, set by that single pass through the crc byte update and adder.
// Reset (rst, synchronous) clears the session to idle and start_address to
// zero; bytes before the first start transaction give an empty event.
// When the receiver stalls, the result register holds; the input register
// fills once more and then in_stall rises until the result is taken.
`timescale 1ns / 1ps
`include "xmodem_crc_receiver_assert.svh"

module xmodem_crc_receiver (
  input  logic        clk,
  input  logic        rst,
  // configuration
  input  logic        cfg_write,
  input  logic [23:0] cfg_data,
  // input channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        action,
  input  logic [7:0]  rx_byte,
  // output channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  event_res,
  output logic [7:0]  data_byte,
  output logic [6:0]  payload_offset,
  output logic [23:0] packet_address,
  output logic        erase_request,
  output logic [7:0]  block_number,
  output logic [24:0] total_bytes,
  output logic [7:0]  lowest_block,
  output logic [7:0]  highest_block
);

  // configuration register
  logic [xcr_pkg::ADDR_W-1:0] start_address;

  // input register
  logic       s1_valid;
  logic       s1_action;
  logic [7:0] s1_byte;

  // session state
  xcr_pkg::session_status_t        status, status_next;
  logic [7:0]                      frame_position, frame_position_next;
  logic [7:0]                      expected_sequence, expected_sequence_next;
  logic [7:0]                      received_sequence, received_sequence_next;
  logic [7:0]                      received_complement, received_complement_next;
  logic [15:0]                     running_crc, running_crc_next;
  logic [7:0]                      crc_high_byte, crc_high_byte_next;
  logic [xcr_pkg::COUNT_W-1:0]     accepted_count, accepted_count_next;
  logic                            erased_valid, erased_valid_next;
  logic [xcr_pkg::BLOCK_IDX_W-1:0] last_erased_block, last_erased_block_next;
  logic [7:0]                      min_block, min_block_next;
  logic [7:0]                      max_block, max_block_next;

  // result of the current pass
  logic [2:0]                      ev;
  logic [7:0]                      dbyte;
  logic [6:0]                      offs;
  logic                            erase;
  logic [7:0]                      blk;
  logic [xcr_pkg::SUM_W-1:0]       target;
  logic [xcr_pkg::BLOCK_IDX_W-1:0] full_idx;
  logic [8:0]                      seq_sum;
  logic [15:0]                     crc_rx;
  logic                            frame_bad;
  logic [xcr_pkg::ADDR_W-1:0]      addr_out;

  // handshake
  logic advance;
  logic in_accept;

  assign advance   = s1_valid && !(out_valid && out_stall);
  assign in_stall  = s1_valid && out_valid && out_stall;
  assign in_accept = in_valid && !in_stall;

  // configuration write
  always_ff @(posedge clk) begin
    if (rst) begin
      start_address <= '0;
    end else if (cfg_write) begin
      start_address <= cfg_data;
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_accept) begin
      s1_valid <= 1'b1;
    end else if (advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_action <= action;
      s1_byte   <= rx_byte;
    end
  end

  // frame checks and flash target
  assign target    = {2'b00, start_address} + {1'b0, accepted_count};
  assign full_idx  = target[xcr_pkg::ADDR_W-1:xcr_pkg::BLOCK_SHIFT];
  assign seq_sum   = {1'b0, received_sequence} + {1'b0, received_complement};
  assign crc_rx    = {crc_high_byte, s1_byte};
  assign frame_bad = (seq_sum != 9'h0FF) || (received_sequence != expected_sequence)
                     || (crc_rx != running_crc);

  // parser, one byte per pass
  always_comb begin
    status_next              = status;
    frame_position_next      = frame_position;
    expected_sequence_next   = expected_sequence;
    received_sequence_next   = received_sequence;
    received_complement_next = received_complement;
    running_crc_next         = running_crc;
    crc_high_byte_next       = crc_high_byte;
    accepted_count_next      = accepted_count;
    erased_valid_next        = erased_valid;
    last_erased_block_next   = last_erased_block;
    min_block_next           = min_block;
    max_block_next           = max_block;
    ev    = xcr_pkg::EV_NONE;
    dbyte = 8'h00;
    offs  = 7'd0;
    erase = 1'b0;
    blk   = 8'h00;

    if (s1_action == xcr_pkg::ACT_START) begin
      status_next              = xcr_pkg::ST_ACTIVE;
      frame_position_next      = 8'd0;
      expected_sequence_next   = 8'd1;
      received_sequence_next   = 8'd0;
      received_complement_next = 8'd0;
      running_crc_next         = 16'h0000;
      crc_high_byte_next       = 8'h00;
      accepted_count_next      = '0;
      erased_valid_next        = 1'b0;
      last_erased_block_next   = '0;
      min_block_next           = 8'hFF;
      max_block_next           = 8'h00;
    end else if (status == xcr_pkg::ST_ACTIVE) begin
      if (frame_position == 8'd0) begin
        // start of frame: soh, eot or a bad byte
        if (s1_byte == xcr_pkg::SOH_BYTE) begin
          running_crc_next    = 16'h0000;
          frame_position_next = xcr_pkg::POS_SEQ;
        end else if (s1_byte == xcr_pkg::EOT_BYTE) begin
          ev          = xcr_pkg::EV_END;
          status_next = xcr_pkg::ST_ENDED;
        end else begin
          ev          = xcr_pkg::EV_CANCEL;
          status_next = xcr_pkg::ST_CANCELLED;
        end
      end else if (frame_position == xcr_pkg::POS_SEQ) begin
        received_sequence_next = s1_byte;
        frame_position_next    = xcr_pkg::POS_COMP;
      end else if (frame_position == xcr_pkg::POS_COMP) begin
        received_complement_next = s1_byte;
        frame_position_next      = xcr_pkg::POS_FIRST_PL;
      end else if (frame_position < xcr_pkg::PAYLOAD_END) begin
        // payload byte, reported before the frame is checked
        ev                  = xcr_pkg::EV_PAYLOAD;
        dbyte               = s1_byte;
        offs                = 7'(frame_position - xcr_pkg::POS_FIRST_PL);
        running_crc_next    = xcr_pkg::crc16_byte(running_crc, s1_byte);
        frame_position_next = frame_position + 8'd1;
      end else if (frame_position == xcr_pkg::CRC_HIGH_POS) begin
        crc_high_byte_next  = s1_byte;
        frame_position_next = xcr_pkg::FRAME_LAST;
      end else begin
        // last frame byte: verdict
        frame_position_next = 8'd0;
        if (frame_bad) begin
          ev = xcr_pkg::EV_NAK;
        end else if (target >= xcr_pkg::SUM_W'(xcr_pkg::FLASH_BYTES)) begin
          ev          = xcr_pkg::EV_CANCEL;
          status_next = xcr_pkg::ST_CANCELLED;
        end else begin
          ev                     = xcr_pkg::EV_ACK;
          blk                    = 8'(full_idx);
          accepted_count_next    = accepted_count
                                   + xcr_pkg::COUNT_W'(xcr_pkg::PAYLOAD_BYTES);
          expected_sequence_next = expected_sequence + 8'd1;
          if (!erased_valid || (full_idx != last_erased_block)) begin
            erase                  = 1'b1;
            erased_valid_next      = 1'b1;
            last_erased_block_next = full_idx;
            if (8'(full_idx) < min_block) begin
              min_block_next = 8'(full_idx);
            end
            if (8'(full_idx) > max_block) begin
              max_block_next = 8'(full_idx);
            end
          end
        end
      end
    end
  end

  // packet address: the checked target on ack, else the running address
  assign addr_out = (ev == xcr_pkg::EV_ACK) ? target[xcr_pkg::ADDR_W-1:0]
                    : start_address + accepted_count_next[xcr_pkg::ADDR_W-1:0];

  // session state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      status              <= xcr_pkg::ST_IDLE;
      frame_position      <= 8'd0;
      expected_sequence   <= 8'd1;
      received_sequence   <= 8'd0;
      received_complement <= 8'd0;
      running_crc         <= 16'h0000;
      crc_high_byte       <= 8'h00;
      accepted_count      <= '0;
      erased_valid        <= 1'b0;
      last_erased_block   <= '0;
      min_block           <= 8'hFF;
      max_block           <= 8'h00;
    end else if (advance) begin
      status              <= status_next;
      frame_position      <= frame_position_next;
      expected_sequence   <= expected_sequence_next;
      received_sequence   <= received_sequence_next;
      received_complement <= received_complement_next;
      running_crc         <= running_crc_next;
      crc_high_byte       <= crc_high_byte_next;
      accepted_count      <= accepted_count_next;
      erased_valid        <= erased_valid_next;
      last_erased_block   <= last_erased_block_next;
      min_block           <= min_block_next;
      max_block           <= max_block_next;
    end
  end

  // result register valid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  // result register payload
  always_ff @(posedge clk) begin
    if (advance) begin
      event_res      <= ev;
      data_byte      <= dbyte;
      payload_offset <= offs;
      packet_address <= addr_out;
      erase_request  <= erase;
      block_number   <= blk;
      total_bytes    <= accepted_count_next;
      lowest_block   <= min_block_next;
      highest_block  <= max_block_next;
    end
  end

  // checks
  `XCR_ASSERT_IMPL(a_total_whole_frames, out_valid,
    total_bytes[6:0] == 7'd0, "total byte count not a whole number of frames")
  `XCR_ASSERT_IMPL(a_payload_fields_clear, out_valid && (event_res != xcr_pkg::EV_PAYLOAD),
    (data_byte == 8'h00) && (payload_offset == 7'd0), "payload fields set off a payload event")
  `XCR_ASSERT_IMPL(a_erase_only_on_ack, out_valid && erase_request,
    event_res == xcr_pkg::EV_ACK, "erase request outside an ack")
  `XCR_ASSERT_IMPL(a_position_in_frame, 1'b1,
    frame_position <= xcr_pkg::FRAME_LAST, "frame position beyond the last frame byte")
  `XCR_ASSERT_NEXT(a_eot_ends_session,
    advance && (s1_action == xcr_pkg::ACT_BYTE) && (status == xcr_pkg::ST_ACTIVE)
      && (frame_position == 8'd0) && (s1_byte == xcr_pkg::EOT_BYTE),
    (status == xcr_pkg::ST_ENDED) && out_valid && (event_res == xcr_pkg::EV_END),
    "eot at frame start did not end the session")

endmodule
